### design/co2sfe_pkg.sv
// ----------------------------------------------------------------------------
// co2sfe_pkg
// Types, codes and constants of the CO2 sensor frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

package co2sfe_pkg;

    // input operation codes (s_tuser)
    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_RX   = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // command request kinds
    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_ZERO     = 3'd1;
    localparam logic [2:0] CMD_SPAN     = 3'd2;
    localparam logic [2:0] CMD_ABC_ON   = 3'd3;
    localparam logic [2:0] CMD_ABC_OFF  = 3'd4;
    localparam logic [2:0] CMD_RANGE    = 3'd5;

    localparam logic [2:0] RANGE_SEL_MAX = 3'd4;

    // result kinds (m_tuser)
    localparam logic RES_TX   = 1'b0;
    localparam logic RES_READ = 1'b1;

    // read status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_MAGIC = 3'd1;
    localparam logic [2:0] STATUS_BAD_ECHO  = 3'd2;
    localparam logic [2:0] STATUS_BAD_CHK   = 3'd3;
    localparam logic [2:0] STATUS_TIMEOUT   = 3'd4;

    // frame bytes
    localparam logic [7:0] FRAME_START   = 8'hFF;
    localparam logic [7:0] FRAME_ADDR    = 8'h01;
    localparam logic [7:0] OPC_READ      = 8'h86;
    localparam logic [7:0] OPC_ZERO      = 8'h87;
    localparam logic [7:0] OPC_SPAN      = 8'h88;
    localparam logic [7:0] OPC_ABC       = 8'h79;
    localparam logic [7:0] ABC_ON_ARG    = 8'hA0;
    localparam logic [7:0] OPC_RANGE     = 8'h99;

    localparam int unsigned FRAME_LEN    = 9;
    localparam logic [7:0] TEMP_OFFSET   = 8'd40;
    localparam logic [7:0] TIMEOUT_RESET = 8'd50;
    localparam logic [7:0] TICK_MAX      = 8'd255;

    // full-scale value for each range selection
    function automatic logic [15:0] range_ppm(input logic [2:0] sel);
        logic [15:0] v;
        case (sel)
            3'd0:    v = 16'd1000;
            3'd1:    v = 16'd2000;
            3'd2:    v = 16'd3000;
            3'd3:    v = 16'd5000;
            default: v = 16'd10000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/co2_sensor_frame_engine.sv
// ----------------------------------------------------------------------------
// co2_sensor_frame_engine
// Host side of the 9-byte sensor UART frame exchange: builds command
// frames and checks and decodes read replies.
// ----------------------------------------------------------------------------
// Usage: s_ beats carry one operation each, selected by s_tuser: a command
// request, a byte received from the sensor, or a poll tick. A command gives
// nine m_ beats of kind 0 (frame bytes FF 01 cmd d1..d5 chk, m_tlast on the
// ninth). After a read command, nine received bytes give one m_ beat of
// kind 1 with status and decoded values; enough poll ticks give a timeout
// beat instead. Bytes and ticks while idle give nothing.
// Latency: a result appears on m_ the cycle after its s_ beat is taken.
// Throughput: one s_ beat per cycle while each gives at most one result
// and m_tready is high; a command holds s_tready low until its frame has
// drained, nine m_ beats in all, limited by the single output register.
// Reset: idle, nothing pending, timeout_ticks back to 50.
// Stall: while m_tready is low the pending beat holds and s_tready drops
// once the output register is full; beats with no result still need it free.
// cfg_w writes timeout_ticks and is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module co2_sensor_frame_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: timeout_ticks
    input  wire logic        cfg_wvalid,
    output logic             cfg_wready,
    input  wire logic [7:0]  cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // cmd_kind[2:0] span_ppm[18:3] range_sel[21:19]
                                       // rx_byte[29:22] zero[31:30]
    input  wire logic [1:0]  s_tuser,  // op[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,  // tx_byte[7:0] status[10:8] co2_ppm[26:11]
                                       // min_co2_ppm[42:27] temperature_c[51:43]
                                       // accuracy[59:52] zero[63:60]
    output logic             m_tuser,  // kind
    output logic             m_tlast   // last
);

    // input fields
    logic [2:0]  cmd_kind;
    logic [15:0] span_ppm;
    logic [2:0]  range_sel;
    logic [7:0]  rx_byte;
    co2sfe_pkg::op_t op;

    assign cmd_kind  = s_tdata[2:0];
    assign span_ppm  = s_tdata[18:3];
    assign range_sel = s_tdata[21:19];
    assign rx_byte   = s_tdata[29:22];
    assign op        = co2sfe_pkg::op_t'(s_tuser);

    // state
    logic [7:0] timeout_reg;
    logic       awaiting_reg;
    logic [3:0] rx_count_reg;
    logic [7:0] tick_count_reg;
    logic [7:0] reply_reg [0:7];

    // output register
    logic [3:0]        remain_reg;
    logic [3:0]        idx_reg;
    logic              res_kind_reg;
    logic [7:0]        cmd_byte_reg;
    logic [7:0]        d1_reg;
    logic [7:0]        d2_reg;
    logic [7:0]        chk_reg;
    logic [2:0]        status_reg;
    logic [15:0]       co2_reg;
    logic [15:0]       min_co2_reg;
    logic signed [8:0] temp_reg;
    logic [7:0]        acc_reg;

    logic s_fire;
    logic m_fire;

    assign cfg_wready = 1'b1;
    assign m_tvalid   = (remain_reg != 4'd0);
    assign m_fire     = m_tvalid && m_tready;
    assign s_tready   = (remain_reg == 4'd0) || ((remain_reg == 4'd1) && m_tready);
    assign s_fire     = s_tvalid && s_tready;

    // ---------------------------------------------------------------- command
    logic       cmd_valid;
    logic [7:0] cmd_byte_next;
    logic [7:0] d1_next;
    logic [7:0] d2_next;
    logic [7:0] req_sum;
    logic [7:0] chk_next;
    logic [15:0] range_val;

    assign range_val = co2sfe_pkg::range_ppm(range_sel);

    always_comb begin
        cmd_valid     = 1'b1;
        cmd_byte_next = co2sfe_pkg::OPC_READ;
        d1_next       = 8'd0;
        d2_next       = 8'd0;
        case (cmd_kind)
            co2sfe_pkg::CMD_READ: cmd_byte_next = co2sfe_pkg::OPC_READ;
            co2sfe_pkg::CMD_ZERO: cmd_byte_next = co2sfe_pkg::OPC_ZERO;
            co2sfe_pkg::CMD_SPAN: begin
                // a span of zero falls back to zero calibration
                if (span_ppm == 16'd0) begin
                    cmd_byte_next = co2sfe_pkg::OPC_ZERO;
                end else begin
                    cmd_byte_next = co2sfe_pkg::OPC_SPAN;
                    d1_next       = span_ppm[15:8];
                    d2_next       = span_ppm[7:0];
                end
            end
            co2sfe_pkg::CMD_ABC_ON: begin
                cmd_byte_next = co2sfe_pkg::OPC_ABC;
                d1_next       = co2sfe_pkg::ABC_ON_ARG;
            end
            co2sfe_pkg::CMD_ABC_OFF: cmd_byte_next = co2sfe_pkg::OPC_ABC;
            co2sfe_pkg::CMD_RANGE: begin
                cmd_byte_next = co2sfe_pkg::OPC_RANGE;
                d1_next       = range_val[15:8];
                d2_next       = range_val[7:0];
                cmd_valid     = (range_sel <= co2sfe_pkg::RANGE_SEL_MAX);
            end
            default: cmd_valid = 1'b0;
        endcase
        req_sum  = co2sfe_pkg::FRAME_ADDR + cmd_byte_next + d1_next + d2_next;
        chk_next = 8'd0 - req_sum;
    end

    // ------------------------------------------------------------- reply check
    logic       reply_done;
    logic [7:0] reply_sum;
    logic [2:0] reply_status;

    assign reply_done = (rx_count_reg == 4'(co2sfe_pkg::FRAME_LEN - 1));

    always_comb begin
        reply_sum = reply_reg[1] + reply_reg[2] + reply_reg[3] + reply_reg[4]
                  + reply_reg[5] + reply_reg[6] + reply_reg[7];
        if (reply_reg[0] != co2sfe_pkg::FRAME_START) begin
            reply_status = co2sfe_pkg::STATUS_BAD_MAGIC;
        end else if (reply_reg[1] != co2sfe_pkg::OPC_READ) begin
            reply_status = co2sfe_pkg::STATUS_BAD_ECHO;
        end else if (rx_byte != 8'd0 - reply_sum) begin
            reply_status = co2sfe_pkg::STATUS_BAD_CHK;
        end else begin
            reply_status = co2sfe_pkg::STATUS_OK;
        end
    end

    // ------------------------------------------------------------------ ticks
    logic [7:0] tick_inc;
    logic       tick_expired;

    assign tick_inc     = (tick_count_reg == co2sfe_pkg::TICK_MAX) ?
                          tick_count_reg : tick_count_reg + 8'd1;
    assign tick_expired = (tick_inc >= timeout_reg);

    // --------------------------------------------------------- beat decisions
    logic emit_frame;
    logic emit_reply;
    logic emit_timeout;
    logic emit_any;

    assign emit_frame   = (op == co2sfe_pkg::OP_CMD) && cmd_valid;
    assign emit_reply   = (op == co2sfe_pkg::OP_RX) && awaiting_reg && reply_done;
    assign emit_timeout = (op == co2sfe_pkg::OP_TICK) && awaiting_reg && tick_expired;
    assign emit_any     = emit_frame || emit_reply || emit_timeout;

    // ---------------------------------------------------------- control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= co2sfe_pkg::TIMEOUT_RESET;
            awaiting_reg   <= 1'b0;
            rx_count_reg   <= 4'd0;
            tick_count_reg <= 8'd0;
            remain_reg     <= 4'd0;
            idx_reg        <= 4'd0;
        end else begin
            if (cfg_wvalid && cfg_wready) begin
                timeout_reg <= cfg_wdata;
            end
            // a new result loads the output register in place of the count
            if (m_fire && !(s_fire && emit_any)) begin
                remain_reg <= remain_reg - 4'd1;
                idx_reg    <= idx_reg + 4'd1;
            end
            if (s_fire) begin
                unique case (op)
                    co2sfe_pkg::OP_CMD: begin
                        if (cmd_valid) begin
                            awaiting_reg   <= (cmd_kind == co2sfe_pkg::CMD_READ);
                            rx_count_reg   <= 4'd0;
                            tick_count_reg <= 8'd0;
                            remain_reg     <= 4'(co2sfe_pkg::FRAME_LEN);
                            idx_reg        <= 4'd0;
                        end
                    end
                    co2sfe_pkg::OP_RX: begin
                        if (awaiting_reg) begin
                            if (reply_done) begin
                                awaiting_reg   <= 1'b0;
                                rx_count_reg   <= 4'd0;
                                tick_count_reg <= 8'd0;
                                remain_reg     <= 4'd1;
                                idx_reg        <= 4'd0;
                            end else begin
                                rx_count_reg <= rx_count_reg + 4'd1;
                            end
                        end
                    end
                    co2sfe_pkg::OP_TICK: begin
                        if (awaiting_reg) begin
                            if (tick_expired) begin
                                awaiting_reg   <= 1'b0;
                                rx_count_reg   <= 4'd0;
                                tick_count_reg <= 8'd0;
                                remain_reg     <= 4'd1;
                                idx_reg        <= 4'd0;
                            end else begin
                                tick_count_reg <= tick_inc;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // reply byte store, first eight bytes of the frame
    always_ff @(posedge aclk) begin
        if (s_fire && (op == co2sfe_pkg::OP_RX) && awaiting_reg && !reply_done) begin
            reply_reg[rx_count_reg[2:0]] <= rx_byte;
        end
    end

    // ---------------------------------------------------------- result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (emit_frame) begin
                res_kind_reg <= co2sfe_pkg::RES_TX;
                cmd_byte_reg <= cmd_byte_next;
                d1_reg       <= d1_next;
                d2_reg       <= d2_next;
                chk_reg      <= chk_next;
                status_reg   <= co2sfe_pkg::STATUS_OK;
                co2_reg      <= 16'd0;
                min_co2_reg  <= 16'd0;
                temp_reg     <= 9'sd0;
                acc_reg      <= 8'd0;
            end else if (emit_reply || emit_timeout) begin
                res_kind_reg <= co2sfe_pkg::RES_READ;
                if (emit_timeout) begin
                    status_reg <= co2sfe_pkg::STATUS_TIMEOUT;
                end else begin
                    status_reg <= reply_status;
                end
                // decoded values only on a good reply
                if (emit_reply && (reply_status == co2sfe_pkg::STATUS_OK)) begin
                    co2_reg     <= {reply_reg[2], reply_reg[3]};
                    min_co2_reg <= {reply_reg[6], reply_reg[7]};
                    temp_reg    <= $signed({1'b0, reply_reg[4]})
                                   - $signed({1'b0, co2sfe_pkg::TEMP_OFFSET});
                    acc_reg     <= reply_reg[5];
                end else begin
                    co2_reg     <= 16'd0;
                    min_co2_reg <= 16'd0;
                    temp_reg    <= 9'sd0;
                    acc_reg     <= 8'd0;
                end
            end
        end
    end

    // ------------------------------------------------------------ output mux
    logic [7:0] tx_byte;

    always_comb begin
        tx_byte = 8'd0;
        if (res_kind_reg == co2sfe_pkg::RES_TX) begin
            case (idx_reg)
                4'd0:    tx_byte = co2sfe_pkg::FRAME_START;
                4'd1:    tx_byte = co2sfe_pkg::FRAME_ADDR;
                4'd2:    tx_byte = cmd_byte_reg;
                4'd3:    tx_byte = d1_reg;
                4'd4:    tx_byte = d2_reg;
                4'd8:    tx_byte = chk_reg;
                default: tx_byte = 8'd0;
            endcase
        end
    end

    assign m_tuser = res_kind_reg;
    assign m_tlast = (res_kind_reg == co2sfe_pkg::RES_TX)
                     && (idx_reg == 4'(co2sfe_pkg::FRAME_LEN - 1));
    assign m_tdata = {4'd0, acc_reg, temp_reg, min_co2_reg, co2_reg, status_reg, tx_byte};

endmodule

`default_nettype wire
